// File: design/nearest_color_palette_cache_defines.svh
// ----------------------------------------------------------------------------
// nearest color palette cache assertion macros
// clocked assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef NEAREST_COLOR_PALETTE_CACHE_DEFINES_SVH
`define NEAREST_COLOR_PALETTE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS
// general property, sampled on clk, off during rst
`define NCPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// antecedent implies consequent in the same cycle
`define NCPC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define NCPC_ASSERT(lbl, prop, msg)
`define NCPC_ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif

`endif

// File: design/ncpc_pkg.sv
// ----------------------------------------------------------------------------
// ncpc_pkg
// shared constants, codes and types of the nearest color palette cache
// ----------------------------------------------------------------------------
package ncpc_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W   = $clog2(PALETTE_DEPTH);
  localparam int CNT_W   = $clog2(PALETTE_DEPTH + 1);
  localparam int CAP_W   = 9;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int CH_W    = 8;
  localparam int COLOR_W = 3 * CH_W;
  localparam int PIX_W   = 8;
  localparam int KIND_W  = 2;
  localparam int DIST_W  = 12;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 9'd255;
  localparam logic [DIST_W-1:0] NEAR_LIMIT = 12'd3;
  // larger than any distance, so the first entry always becomes best
  localparam logic [DIST_W-1:0] BEST_INIT  = '1;

  localparam logic [KIND_W-1:0] KIND_HIT     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NEW     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSEST = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd3;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] metric;
  } dist_res_t;

endpackage

// File: design/ncpc_if.sv
// ----------------------------------------------------------------------------
// ncpc_if
// valid/ready channels for color requests and index responses
// ----------------------------------------------------------------------------
interface ncpc_req_if import ncpc_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface ncpc_rsp_if import ncpc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_index;
  logic [KIND_W-1:0] match_kind;

  modport source (output valid, pixel_index, match_kind, input ready);
  modport sink   (input valid, pixel_index, match_kind, output ready);
endinterface

// File: design/ncpc_ram.sv
// ----------------------------------------------------------------------------
// ncpc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ncpc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/ncpc_dist.sv
// ----------------------------------------------------------------------------
// ncpc_dist
// registered color distance: 3 * l1 rgb difference plus channel sum difference
// ----------------------------------------------------------------------------
module ncpc_dist import ncpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic [IDX_W-1:0]   in_idx,
  input  logic               flush,
  input  logic [COLOR_W-1:0] req_color,
  input  logic [COLOR_W-1:0] entry_color,
  output dist_res_t          res
);

  function automatic logic [CH_W-1:0] abs_ch(input logic [CH_W-1:0] a,
                                             input logic [CH_W-1:0] b);
    abs_ch = (a > b) ? (a - b) : (b - a);
  endfunction

  logic [CH_W+1:0]   l1;
  logic [CH_W+1:0]   req_sum;
  logic [CH_W+1:0]   ent_sum;
  logic [CH_W+1:0]   lum;
  logic [DIST_W-1:0] dist_sum;

  always_comb begin
    l1 = (CH_W+2)'(abs_ch(req_color[3*CH_W-1:2*CH_W], entry_color[3*CH_W-1:2*CH_W]))
       + (CH_W+2)'(abs_ch(req_color[2*CH_W-1:CH_W], entry_color[2*CH_W-1:CH_W]))
       + (CH_W+2)'(abs_ch(req_color[CH_W-1:0], entry_color[CH_W-1:0]));
    req_sum = (CH_W+2)'(req_color[3*CH_W-1:2*CH_W]) + (CH_W+2)'(req_color[2*CH_W-1:CH_W])
            + (CH_W+2)'(req_color[CH_W-1:0]);
    ent_sum = (CH_W+2)'(entry_color[3*CH_W-1:2*CH_W])
            + (CH_W+2)'(entry_color[2*CH_W-1:CH_W])
            + (CH_W+2)'(entry_color[CH_W-1:0]);
    lum  = (req_sum > ent_sum) ? (req_sum - ent_sum) : (ent_sum - req_sum);
    // times three as shift plus add
    dist_sum = DIST_W'({l1, 1'b0}) + DIST_W'(l1) + DIST_W'(lum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.vld <= 1'b0;
    end else begin
      res.vld <= in_vld && !flush;
    end
    res.idx    <= in_idx;
    res.metric <= dist_sum;
  end

endmodule

// File: design/nearest_color_palette_cache.sv
// ----------------------------------------------------------------------------
// nearest_color_palette_cache
// maps rgb requests to palette indexes, allocating new entries until full
// ----------------------------------------------------------------------------
// req carries one rgb color per beat; rsp returns one pixel_index and
// match_kind per request, in order. cfg_we with cfg_data sets the palette
// capacity (reset 255); write it only while no request is in flight.
// A request is taken only when the sequencer is idle. It then scans the
// stored entries in palette ram, one read issued per cycle, each read
// followed by a registered distance stage. The scan stops on the first
// entry closer than 3; otherwise it ends after all used entries and
// appends the color, returns the closest one, or reports an empty palette
// when nothing is stored and there is no room. A new request is taken only
// after the previous result has left the sequencer.
// Reset empties the palette (used count zero) and needs no clearing pass.
// A finished result sits in the rsp output register; while the receiver
// stalls it is held there, the next request is still taken and scanned,
// and its result waits in the sequencer until the register drains.
// ----------------------------------------------------------------------------
`include "nearest_color_palette_cache_defines.svh"

module nearest_color_palette_cache import ncpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  ncpc_req_if.sink         req,
  ncpc_rsp_if.source       rsp
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t             state;
  logic [CAP_W-1:0]   capacity;
  logic [CNT_W-1:0]   used_count;
  logic [COLOR_W-1:0] color;
  logic [CNT_W-1:0]   issue_cnt;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic [DIST_W-1:0]  best_dist;
  logic [IDX_W-1:0]   best_idx;
  logic [PIX_W-1:0]   res_idx;
  logic [KIND_W-1:0]  res_kind;

  logic [COLOR_W-1:0] rd_data;
  dist_res_t          dres;
  logic               issue;
  logic               hit;
  logic               finish;
  logic               full;
  logic               ram_we;
  logic               in_scan;

  ncpc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (used_count[IDX_W-1:0]),
    .wdata (color),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (rd_data)
  );

  ncpc_dist u_dist (
    .clk         (clk),
    .rst         (rst),
    .in_vld      (rd_vld),
    .in_idx      (rd_idx),
    .flush       (hit),
    .req_color   (color),
    .entry_color (rd_data),
    .res         (dres)
  );

  always_comb begin
    in_scan = (state == S_SCAN);
    issue   = in_scan && (issue_cnt < used_count);
    hit     = in_scan && dres.vld && (dres.metric < NEAR_LIMIT);
    finish  = in_scan && !issue && !rd_vld && !dres.vld;
    full    = (CMP_W'(used_count) >= CMP_W'(capacity))
           || (used_count == CNT_W'(PALETTE_DEPTH));
    ram_we  = finish && !full;
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      rd_vld     <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      rd_vld <= issue && !hit;
      if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit || finish) begin
            state <= S_DONE;
          end
          if (ram_we) begin
            used_count <= used_count + 1'b1;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      color     <= {req.red_in, req.green_in, req.blue_in};
      issue_cnt <= '0;
      best_dist <= BEST_INIT;
      best_idx  <= '0;
    end
    if (issue) begin
      issue_cnt <= issue_cnt + 1'b1;
    end
    rd_idx <= issue_cnt[IDX_W-1:0];
    if (hit) begin
      res_idx  <= PIX_W'(dres.idx);
      res_kind <= KIND_HIT;
    end else if (in_scan && dres.vld && (dres.metric < best_dist)) begin
      best_dist <= dres.metric;
      best_idx  <= dres.idx;
    end
    if (finish) begin
      if (!full) begin
        res_idx  <= PIX_W'(used_count[IDX_W-1:0]);
        res_kind <= KIND_NEW;
      end else if (used_count == '0) begin
        res_idx  <= '0;
        res_kind <= KIND_EMPTY;
      end else begin
        res_idx  <= PIX_W'(best_idx);
        res_kind <= KIND_CLOSEST;
      end
    end
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.pixel_index <= res_idx;
      rsp.match_kind  <= res_kind;
    end
  end

  `NCPC_ASSERT(a_accept_scan, (req.valid && req.ready) |=> (state == S_SCAN), "accepted beat did not start a scan")
  `NCPC_ASSERT_IMPLIES(a_count_bound, 1'b1, used_count <= CNT_W'(PALETTE_DEPTH), "used count above palette depth")
  `NCPC_ASSERT_IMPLIES(a_grow_new, !$past(rst) && (used_count != $past(used_count)), (state == S_DONE) && (res_kind == KIND_NEW), "palette grew without an allocation")
  `NCPC_ASSERT_IMPLIES(a_no_scan_write, ram_we, !rd_vld && !dres.vld && !issue, "palette written during a scan")

endmodule
